>>> src/fdl_pkg.sv
// Shared types and constants of the feedback delay line.
// Holds register indexes, register widths and reset values, and the
// command and status records between the controller and the datapath.
`default_nettype none

package fdl_pkg;

  localparam int IDX_W      = 2;
  localparam int CFG_DATA_W = 20;
  localparam int DELAY_W    = 20;
  localparam int LEN_W      = 13;
  localparam int GAIN_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int COEF_W     = 17;

  localparam logic [IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_LENGTH_IN_USE = 2'd1;
  localparam logic [IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd2;
  localparam logic [IDX_W-1:0] REG_WET_MIX       = 2'd3;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd256000;
  localparam logic [LEN_W-1:0]   LEN_RESET   = 13'd4096;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
  localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;
  localparam logic [LEN_W-1:0]   LEN_MIN     = 13'd2;

  // One bit per sequencer step; the datapath acts on whichever is set.
  typedef struct packed {
    logic clear;
    logic accept;
    logic prep;
    logic ptr;
    logic rd_before;
    logic rd_after;
    logic interp;
    logic fb;
    logic wr;
    logic mix;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> src/feedback_delay_line_core.sv
// Top level of the feedback delay line: fdl_ctrl sequences fdl_datapath.
// Depends on fdl_pkg for register indexes and the command records.
//
// Requests are taken one at a time; the next is taken even while a result
// still waits in the output register. The mix step writes each result to
// that register and waits while a stalled result holds it. The pace is set
// by the single read port of the sample store, which fetches both
// interpolation neighbors in turn, and by the one shared multiplier, which
// does the two interpolation products, the feedback product and both mix
// products in five successive steps. After reset the store is cleared one
// entry per cycle over all CHANNELS * MAX_LENGTH entries, and in_stall_o
// stays high until that pass is done; configuration writes are taken at
// any time and should only be made while no request is in flight.
`default_nettype none

module feedback_delay_line_core #(
  parameter int MAX_LENGTH  = 4096,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]                    sample_in_i,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] channel_i,
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]                    sample_out_o,
  input  logic                                             cfg_valid_i,
  output logic                                             cfg_ready_o,
  input  logic [fdl_pkg::IDX_W-1:0]                        cfg_index_i,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]                   cfg_data_i
);
  import fdl_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  fdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdl_datapath #(
    .MAX_LENGTH  (MAX_LENGTH),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .channel_i    (channel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

endmodule

`default_nettype wire

>>> src/fdl_ctrl.sv
// Sequencer of the feedback delay line: clearing pass, then one request
// at a time through eight steps. Uses fdl_pkg for the command and status types.
`default_nettype none

module fdl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fdl_pkg::status_t status_i,
  output fdl_pkg::cmd_t    cmd_o
);
  import fdl_pkg::*;

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_PREP   = 4'd2;
  localparam logic [3:0] ST_PTR    = 4'd3;
  localparam logic [3:0] ST_RD0    = 4'd4;
  localparam logic [3:0] ST_RD1    = 4'd5;
  localparam logic [3:0] ST_INTERP = 4'd6;
  localparam logic [3:0] ST_FB     = 4'd7;
  localparam logic [3:0] ST_WR     = 4'd8;
  localparam logic [3:0] ST_MIX    = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_PTR;
      end
      ST_PTR: begin
        cmd_o.ptr = 1'b1;
        state_d   = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.rd_before = 1'b1;
        state_d         = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_after = 1'b1;
        state_d        = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_FB;
      end
      ST_FB: begin
        cmd_o.fb = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_MIX;
      end
      ST_MIX: begin
        // Hold the finished sample until the output register is free.
        if (!status_i.out_busy) begin
          cmd_o.mix = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> src/fdl_datapath.sv
// Datapath of the feedback delay line: configuration registers, write
// positions, sample store, one shared multiplier and the output register.
// Driven by fdl_ctrl through the command record of fdl_pkg.
`default_nettype none

module fdl_datapath #(
  parameter int MAX_LENGTH  = 4096,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  fdl_pkg::cmd_t                                    cmd_i,
  output fdl_pkg::status_t                                 status_o,
  input  logic                                             cfg_valid_i,
  input  logic [fdl_pkg::IDX_W-1:0]                        cfg_index_i,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]                   cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]                    sample_in_i,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] channel_i,
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]                    sample_out_o
);
  import fdl_pkg::*;

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(MAX_LENGTH);
  localparam int LW    = PW + 1;
  localparam int SW    = LW + FRAC_BITS;
  localparam int DEPTH = CHANNELS * MAX_LENGTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SB    = SAMPLE_BITS;
  localparam int PRODW = SB + COEF_W + 1;
  localparam int ACCW  = PRODW + 1;

  localparam logic signed [ACCW-1:0] SAT_HI = (ACCW'(1) << (SB - 1)) - ACCW'(1);
  localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);
  localparam logic signed [ACCW-1:0] RND_D  = ACCW'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] RND_G  = ACCW'(16384);

  function automatic logic signed [SB-1:0] sat(input logic signed [ACCW-1:0] v);
    logic signed [ACCW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[SB-1:0];
  endfunction

  // Configuration registers.
  logic [DELAY_W-1:0] delay_q;
  logic [LEN_W-1:0]   len_cfg_q;
  logic [GAIN_W-1:0]  fb_cfg_q;
  logic [GAIN_W-1:0]  mix_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q   <= DELAY_RESET;
      len_cfg_q <= LEN_RESET;
      fb_cfg_q  <= GAIN_RESET;
      mix_cfg_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DELAY_LENGTH:  delay_q   <= cfg_data_i[DELAY_W-1:0];
        REG_LENGTH_IN_USE: len_cfg_q <= cfg_data_i[LEN_W-1:0];
        REG_FEEDBACK_GAIN: fb_cfg_q  <= cfg_data_i[GAIN_W-1:0];
        REG_WET_MIX:       mix_cfg_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Request registers.
  logic signed [SB-1:0] x_q;
  logic [CH_W-1:0]      ch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_in_i;
      if (32'(channel_i) >= CHANNELS) begin
        ch_q <= CH_W'(CHANNELS - 1);
      end else begin
        ch_q <= channel_i;
      end
    end
  end

  // Clamped settings and the effective write position.
  logic [LW-1:0]     len_c, len_q;
  logic [SW-1:0]     span_c, dly_c, dly_q;
  logic [GAIN_W-1:0] fb_q, mix_q;
  logic [PW-1:0]     wp_q [CHANNELS];
  logic [PW-1:0]     wp_cur, wp_eff_q, wp_next;
  logic [AW-1:0]     base_q;

  always_comb begin
    if (len_cfg_q < LEN_MIN) begin
      len_c = LW'(LEN_MIN);
    end else if (32'(len_cfg_q) > MAX_LENGTH) begin
      len_c = LW'(MAX_LENGTH);
    end else begin
      len_c = LW'(len_cfg_q);
    end
    span_c = {len_c, {FRAC_BITS{1'b0}}};
    if (32'(delay_q) >= 32'(span_c)) begin
      dly_c = span_c - SW'(1);
    end else begin
      dly_c = SW'(delay_q);
    end
  end

  assign wp_cur = wp_q[ch_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      len_q    <= len_c;
      dly_q    <= dly_c;
      fb_q     <= (fb_cfg_q > GAIN_ONE) ? GAIN_ONE : fb_cfg_q;
      mix_q    <= (mix_cfg_q > GAIN_ONE) ? GAIN_ONE : mix_cfg_q;
      wp_eff_q <= (LW'(wp_cur) >= len_c) ? '0 : wp_cur;
      base_q   <= AW'(32'(ch_q) * MAX_LENGTH);
    end
  end

  // Read pointer: write position minus delay, wrapped over the span.
  logic [SW:0]          rp_diff;
  logic [SW-1:0]        rp_c;
  logic [PW-1:0]        before_q, after_q, before_c;
  logic [FRAC_BITS-1:0] frac_q;

  always_comb begin
    rp_diff = {1'b0, LW'(wp_eff_q), {FRAC_BITS{1'b0}}} - {1'b0, dly_q};
    if (rp_diff[SW]) begin
      rp_c = rp_diff[SW-1:0] + {len_q, {FRAC_BITS{1'b0}}};
    end else begin
      rp_c = rp_diff[SW-1:0];
    end
    before_c = rp_c[PW+FRAC_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ptr) begin
      before_q <= before_c;
      frac_q   <= rp_c[FRAC_BITS-1:0];
      after_q  <= (LW'(before_c) + LW'(1) >= len_q) ? '0 : before_c + PW'(1);
    end
  end

  assign wp_next = (LW'(wp_eff_q) + LW'(1) >= len_q) ? '0 : wp_eff_q + PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
    end else if (cmd_i.wr) begin
      wp_q[ch_q] <= wp_next;
    end
  end

  // Clearing pass over the whole store after reset.
  logic [AW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign status_o.clear_last = (clr_q == AW'(DEPTH - 1));

  // Shared multiplier: signed sample times unsigned coefficient.
  logic signed [SB-1:0]     mul_a;
  logic [COEF_W-1:0]        mul_b;
  logic signed [COEF_W:0]   mul_bs;
  logic signed [PRODW-1:0]  mul_p;
  logic signed [SB-1:0]     rd_q, d_q;
  logic signed [ACCW-1:0]   acc_q;

  always_comb begin
    mul_a = d_q;
    mul_b = COEF_W'(mix_q);
    if (cmd_i.rd_after) begin
      mul_a = rd_q;
      mul_b = COEF_W'(1 << FRAC_BITS) - COEF_W'(frac_q);
    end else if (cmd_i.interp) begin
      mul_a = rd_q;
      mul_b = COEF_W'(frac_q);
    end else if (cmd_i.fb) begin
      mul_a = d_q;
      mul_b = COEF_W'(fb_q);
    end else if (cmd_i.wr) begin
      mul_a = x_q;
      mul_b = COEF_W'(GAIN_ONE) - COEF_W'(mix_q);
    end
    mul_bs = $signed({1'b0, mul_b});
    mul_p  = PRODW'(mul_a) * PRODW'(mul_bs);
  end

  logic signed [ACCW-1:0] sum_c, d_sum, w_sum, o_sum;

  always_comb begin
    sum_c = acc_q + ACCW'(mul_p);
    d_sum = (sum_c + RND_D) >>> FRAC_BITS;
    w_sum = ACCW'(x_q) + ((acc_q + RND_G) >>> 15);
    o_sum = (sum_c + RND_G) >>> 15;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_after || cmd_i.fb || cmd_i.wr) begin
      acc_q <= ACCW'(mul_p);
    end
    if (cmd_i.interp) begin
      d_q <= d_sum[SB-1:0];
    end
  end

  // Sample store: one write port, one registered read port.
  logic [SB-1:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SB-1:0] mem_wdata;

  assign mem_we    = cmd_i.clear || cmd_i.wr;
  assign mem_waddr = cmd_i.clear ? clr_q : base_q + AW'(wp_eff_q);
  assign mem_wdata = cmd_i.clear ? '0 : sat(w_sum);
  assign mem_re    = cmd_i.rd_before || cmd_i.rd_after;
  assign mem_raddr = base_q + AW'(cmd_i.rd_before ? before_q : after_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Output register.
  logic                 out_valid_q;
  logic signed [SB-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.mix) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mix) begin
      out_q <= sat(o_sum);
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

endmodule

`default_nettype wire

>>> src/fdl_checker.sv
// Port-level checks of feedback_delay_line_core, and the bind that
// attaches them. Sees only the top level's ports.
`default_nettype none

module fdl_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_o
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("stalled result changed or was dropped");

  // Only one request is in the sequencer at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  // A new result must be traced back to a request that was taken.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 9))
    else $error("result appeared without a matching request");

endmodule

bind feedback_delay_line_core fdl_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_fdl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o)
);

`default_nettype wire

>>> tb/fdl_monitor.sv
`timescale 1ns / 1ps
// Monitor for feedback_delay_line_core: follows the sample, result and register
// channels, models the delay store and compares every result. Needs fdl_pkg.
module fdl_monitor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic signed [15:0]               sample_in_i,
  input  logic [0:0]                       channel_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [15:0]               sample_out_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [fdl_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [fdl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);
  import fdl_pkg::*;

  localparam int MAX_LENGTH = 4096;
  localparam int CHANNELS   = 2;

  logic signed [15:0]   echo_mem [0:CHANNELS*MAX_LENGTH-1];
  int                   wr_pos [CHANNELS];
  logic [DELAY_W-1:0]   tap_delay;
  logic [LEN_W-1:0]     line_len;
  logic [GAIN_W-1:0]    fb_gain;
  logic [GAIN_W-1:0]    wet_gain;
  logic signed [15:0]   mix_due [$];
  logic signed [15:0]   want;
  int                   err_cnt = 0;
  int                   result_cnt = 0;

  assign errors_o = err_cnt;

  task automatic report_mismatch(input string msg);
    $display("%0t ns fdl_monitor: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Reads the interpolated tap, writes the fed-back sample and queues the mix.
  task automatic apply_echo_tap(input logic signed [15:0] dry, input logic [0:0] ch);
    longint x, len, fb, wet, base, wp, span, dly, rp, lo_tap, hi_tap, frac, tap, fed, mixed;
    x    = dry;
    len  = line_len;
    fb   = (fb_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(fb_gain);
    wet  = (wet_gain > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(wet_gain);
    if (len < 2) len = 2;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    base = longint'(ch) * MAX_LENGTH;
    wp   = wr_pos[ch];
    // A shrunk length can leave the write position outside the line.
    if (wp >= len) wp = 0;
    span = len << FRAC_BITS;
    dly  = tap_delay;
    if (dly >= span) dly = span - 1;
    rp = (wp << FRAC_BITS) - dly;
    if (rp < 0) rp += span;
    lo_tap = rp >> FRAC_BITS;
    if (lo_tap >= len) lo_tap = 0;
    frac   = rp & 255;
    hi_tap = lo_tap + 1;
    if (hi_tap >= len) hi_tap = 0;
    tap = longint'(echo_mem[base + lo_tap]) * (256 - frac)
        + longint'(echo_mem[base + hi_tap]) * frac;
    tap = (tap + 128) >>> FRAC_BITS;
    fed = x + ((fb * tap + 16384) >>> 15);
    echo_mem[base + wp] = clip16(fed);
    mixed = (32768 - wet) * x + wet * tap;
    mix_due.push_back(clip16((mixed + 16384) >>> 15));
    wp++;
    if (wp >= len) wp = 0;
    wr_pos[ch] = int'(wp);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS * MAX_LENGTH; i++) echo_mem[i] = '0;
      for (int c = 0; c < CHANNELS; c++) wr_pos[c] = 0;
      tap_delay = DELAY_RESET;
      line_len  = LEN_RESET;
      fb_gain   = GAIN_RESET;
      wet_gain  = GAIN_RESET;
      mix_due.delete();
      pending_o = 0;
    end else begin
      // Results leave a register, so a result never belongs to a request
      // taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (mix_due.size() == 0) begin
          report_mismatch($sformatf("result %0d: sample_out %0d with no request outstanding",
                                    result_cnt, sample_out_i));
        end else begin
          want = mix_due.pop_front();
          if (sample_out_i !== want)
            report_mismatch($sformatf("result %0d: sample_out %0d, expected %0d",
                                      result_cnt, sample_out_i, want));
        end
        result_cnt++;
      end
      if (in_valid_i && !in_stall_i) apply_echo_tap(sample_in_i, channel_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DELAY_LENGTH:  tap_delay = cfg_data_i[DELAY_W-1:0];
          REG_LENGTH_IN_USE: line_len  = cfg_data_i[LEN_W-1:0];
          REG_FEEDBACK_GAIN: fb_gain   = cfg_data_i[GAIN_W-1:0];
          REG_WET_MIX:       wet_gain  = cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
      pending_o = mix_due.size();
    end
  end

endmodule

>>> tb/tb_feedback_delay_line_core.sv
`timescale 1ns / 1ps
// Testbench top for feedback_delay_line_core: clock, reset, sample requests,
// register writes, output stalls and the verdict. Needs fdl_pkg and fdl_monitor.
module tb_feedback_delay_line_core;
  import fdl_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRESS_ITEMS  = 30;
  localparam int QUIET_LIMIT  = 40000;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [15:0]     sample_in;
  logic [0:0]             channel;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [15:0]     sample_out;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int errors;
  int pending;
  int items_sent   = 0;
  int reg_writes   = 0;
  int settings_cnt = 0;
  int quiet        = 0;
  bit hold_go      = 1'b0;
  bit holding      = 1'b0;

  always #5 clk = ~clk;

  feedback_delay_line_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .channel_i    (channel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  fdl_monitor mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .sample_in_i  (sample_in),
    .channel_i    (channel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_i (sample_out),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // The clear pass after reset is the longest quiet stretch of a correct run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("tb_feedback_delay_line_core: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] dly, input logic [CFG_DATA_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] fb, input logic [CFG_DATA_W-1:0] wet);
    write_reg(REG_DELAY_LENGTH, dly);
    write_reg(REG_LENGTH_IN_USE, len);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_WET_MIX, wet);
    settings_cnt++;
  endtask

  // Valid stays high after acceptance; the next negedge either offers the
  // next request or drops valid, never both.
  task automatic send_sample(input logic signed [15:0] x, input logic [0:0] ch);
    @(negedge clk);
    in_valid  <= 1'b1;
    sample_in <= x;
    channel   <= ch;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic pause_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'(int'($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    if ($urandom_range(0, 3) == 0) v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 9))
      0:       v[GAIN_W-1:0] = '0;
      1:       v[GAIN_W-1:0] = GAIN_ONE;
      2:       v[GAIN_W-1:0] = GAIN_W'($urandom_range(32769, 65535));
      default: v[GAIN_W-1:0] = GAIN_W'($urandom_range(0, 32768));
    endcase
    return v;
  endfunction

  // Mostly short lines so the taps land on samples written in the same phase.
  function automatic logic [CFG_DATA_W-1:0] pick_length();
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    if ($urandom_range(0, 3) == 0) v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 19))
      0:                        v[LEN_W-1:0] = LEN_W'($urandom_range(0, 1));
      1:                        v[LEN_W-1:0] = LEN_W'($urandom_range(4097, 8191));
      2:                        v[LEN_W-1:0] = LEN_RESET;
      3:                        v[LEN_W-1:0] = LEN_MIN;
      4, 5, 6, 7, 8, 9, 10, 11: v[LEN_W-1:0] = LEN_W'($urandom_range(2, 32));
      12, 13, 14, 15, 16:       v[LEN_W-1:0] = LEN_W'($urandom_range(33, 512));
      default:                  v[LEN_W-1:0] = LEN_W'($urandom_range(513, 4096));
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay(input int line_samples);
    int span;
    span = line_samples * 256;
    case ($urandom_range(0, 9))
      0: return 20'hfffff;
      1: return CFG_DATA_W'(span - 1);
      2: return '0;
      3: begin
        if (span > 20'hfffff) return 20'hfffff;
        return CFG_DATA_W'($urandom_range(span, 20'hfffff));
      end
      4: return CFG_DATA_W'($urandom_range(0, 1023));
      default: return CFG_DATA_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  initial begin : receiver
    int mode;
    int span_len;
    forever begin
      if (hold_go) begin
        @(negedge clk);
        out_stall <= 1'b1;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
        hold_go = 1'b0;
      end
      mode     = $urandom_range(0, 3);
      span_len = $urandom_range(10, 90);
      for (int tick = 0; tick < span_len; tick++) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 4) != 0);
          default: out_stall <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] len_word;
    int  line_samples;
    int  phase_left;
    int  burst;
    bit  steady;
    bit  pressed;
    int  fixed_ch;

    pressed   = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    sample_in = '0;
    channel   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: the long delay reads the cleared store.
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);

    // Fractional short delay with both gains above one; feedback saturates.
    settle();
    apply_setting(20'h00180, 20'd16, 20'h0ffff, 20'h0ffff);
    repeat (6) send_sample(16'sh7fff, 1'b0);
    repeat (3) send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh4000, 1'b1);

    // Length below the minimum, delay past the line, and a write position
    // left beyond the shrunk length on channel 0.
    settle();
    apply_setting(20'hfffff, 20'd0, 20'd32768, 20'd0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd123, 1'b1);
    send_sample(-16'sd456, 1'b1);

    // Length above the maximum, zero delay, no feedback, fully wet.
    settle();
    apply_setting(20'd0, 20'h01fff, 20'd0, 20'd32768);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);

    while (items_sent < 24 + RANDOM_ITEMS) begin
      settle();
      len_word     = pick_length();
      line_samples = len_word[LEN_W-1:0];
      if (line_samples < 2) line_samples = 2;
      if (line_samples > 4096) line_samples = 4096;
      apply_setting(pick_delay(line_samples), len_word, pick_gain(), pick_gain());

      // Hold the output long enough that the core fills and stalls requests.
      if (!pressed && settings_cnt >= 6) begin
        pressed = 1'b1;
        hold_go = 1'b1;
        wait (holding);
        repeat (PRESS_ITEMS) send_sample(pick_sample(), 1'($urandom_range(0, 1)));
      end

      phase_left = $urandom_range(40, 160);
      steady     = ($urandom_range(0, 3) == 0);
      fixed_ch   = $urandom_range(0, 5);
      while (phase_left > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && phase_left > 0) begin
          send_sample(pick_sample(),
                      (fixed_ch < 2) ? 1'(fixed_ch) : 1'($urandom_range(0, 1)));
          burst--;
          phase_left--;
        end
        if (!steady && phase_left > 0) pause_input($urandom_range(1, 20));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    $display("Ran %0d samples on both channels over %0d settings (%0d register writes),",
             items_sent, settings_cnt, reg_writes);
    $display("with out-of-range lengths, delays and gains and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("tb_feedback_delay_line_core: done, clean");
    end else begin
      $display("tb_feedback_delay_line_core: done, errors");
    end
    $finish;
  end

endmodule
